@@ rtl/bpa_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants, codes and types of the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int NUM_ORDERS = 8;
  localparam int MAX_PAGES  = 4096;
  localparam int PAGE_W     = 12;
  localparam int LINK_W     = 13;
  localparam int ORD_W      = 4;
  localparam int OIX_W      = 3;
  localparam int CFG_W      = 13;
  localparam int OP_W       = 2;
  localparam int STAT_W     = 2;

  // empty list or link
  localparam logic [LINK_W-1:0] NIL_PAGE = LINK_W'(MAX_PAGES);

  typedef enum logic [OP_W-1:0] {
    OP_REBUILD = 2'd0,
    OP_ALLOC   = 2'd1,
    OP_FREE    = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_BAD_ORDER = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DISP,
    S_RB_CLR, S_RB_FIT, S_RB_PB,
    S_A_CHK, S_A_POP, S_A_MARK, S_A_SPL, S_A_PUSH, S_A_PB,
    S_F_SRCH, S_F_RD, S_F_CLR, S_F_BUD, S_F_UH, S_F_UN, S_F_PUSH, S_F_PB,
    S_DONE
  } state_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_SWEEP,
    CMD_ST_BADORD, CMD_ST_NOSPACE, CMD_ST_BADFREE,
    CMD_ABITS_RD, CMD_ORD_INC, CMD_ORD_DEC,
    CMD_PUSH_RB, CMD_PUSH_SPLIT, CMD_PUSH_FREE, CMD_PUSH_B,
    CMD_POP_RD, CMD_POP_WR, CMD_MARK,
    CMD_F_FOUND, CMD_F_CLR,
    CMD_UH_RD, CMD_UH_WR, CMD_UN_RD, CMD_UN_WR,
    CMD_EMIT
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic req_bad;
    logic pg_oob;
    logic head_empty;
    logic ord_last;
    logic ord_zero;
    logic fit;
    logic split_more;
    logic found;
    logic bud_oob;
    logic bud_alloc;
    logic bud_is_head;
    logic sweep_last;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

@@ rtl/bpa_ifs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_ifs
// Request and result channels of the buddy page allocator.
// ----------------------------------------------------------------------------
interface bpa_in_if;
  import bpa_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [ORD_W-1:0]    req_order;
  logic [PAGE_W-1:0]   rel_page;
  modport source(output valid, opcode, req_order, rel_page, input ready);
  modport sink(input valid, opcode, req_order, rel_page, output ready);
endinterface

interface bpa_out_if;
  import bpa_pkg::*;
  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic [PAGE_W-1:0]   block_page;
  logic [ORD_W-1:0]    final_order;
  modport source(output valid, status, block_page, final_order, input ready);
  modport sink(input valid, status, block_page, final_order, output ready);
endinterface
`default_nettype wire

@@ rtl/buddy_page_allocator_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// buddy_page_allocator_top
// Buddy page allocator with per-order free lists and allocated bitmap.
// ----------------------------------------------------------------------------
// One request is handled at a time; the result register lets the next request
// in while a result waits. After reset the bitmap is cleared before the first
// request is taken. Rebuild sweeps the bitmap clear and then pushes blocks
// from the top order down; allocate scans up from the requested order past
// empty lists and then splits; free merges with free buddies. The bitmap and
// link memories have one write port and one registered read port, so every
// list update is a read and a write in separate cycles.
module buddy_page_allocator_top (
  input  logic                      clk,
  input  logic                      rst_n,
  bpa_in_if.sink                    in_chan,
  bpa_out_if.source                 out_chan,
  input  logic                      cfg_we,
  input  logic [bpa_pkg::CFG_W-1:0] cfg_data
);
  import bpa_pkg::*;

  cmd_t       cmd;
  dp_status_t st;
  logic       in_ready;

  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  bpa_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .ld_opcode     (in_chan.opcode),
    .ld_req_order  (in_chan.req_order),
    .ld_rel_page   (in_chan.rel_page),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .res_valid     (out_chan.valid),
    .res_ready     (out_chan.ready),
    .res_status    (out_chan.status),
    .res_page      (out_chan.block_page),
    .res_order     (out_chan.final_order)
  );

  assign in_chan.ready = in_ready;

endmodule
`default_nettype wire

@@ rtl/bpa_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer of the allocator: walks rebuild, allocate and free step by step
// and issues one datapath command per cycle.
// ----------------------------------------------------------------------------
module bpa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bpa_pkg::dp_status_t st,
  output bpa_pkg::cmd_t       cmd
);
  import bpa_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT:   if (st.sweep_last) state_nxt = S_IDLE;
      S_IDLE:   if (in_valid) state_nxt = S_DISP;
      S_DISP: begin
        case (st.op)
          OP_REBUILD: state_nxt = S_RB_CLR;
          OP_ALLOC:   state_nxt = st.req_bad ? S_DONE : S_A_CHK;
          OP_FREE:    state_nxt = st.pg_oob ? S_DONE : S_F_SRCH;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_RB_CLR: if (st.sweep_last) state_nxt = S_RB_FIT;
      S_RB_FIT: begin
        if (st.fit) state_nxt = S_RB_PB;
        else if (st.ord_zero) state_nxt = S_DONE;
      end
      S_RB_PB:  state_nxt = S_RB_FIT;
      S_A_CHK: begin
        if (!st.head_empty) state_nxt = S_A_POP;
        else if (st.ord_last) state_nxt = S_DONE;
      end
      S_A_POP:  state_nxt = S_A_MARK;
      S_A_MARK: state_nxt = S_A_SPL;
      S_A_SPL:  state_nxt = st.split_more ? S_A_PUSH : S_DONE;
      S_A_PUSH: state_nxt = S_A_PB;
      S_A_PB:   state_nxt = S_A_SPL;
      S_F_SRCH: state_nxt = st.found ? S_F_RD : S_DONE;
      S_F_RD:   state_nxt = S_F_CLR;
      S_F_CLR:  state_nxt = (st.ord_last || st.bud_oob) ? S_F_PUSH : S_F_BUD;
      S_F_BUD: begin
        if (st.bud_alloc) state_nxt = S_F_PUSH;
        else if (st.bud_is_head) state_nxt = S_F_UH;
        else state_nxt = S_F_UN;
      end
      S_F_UH:   state_nxt = S_F_RD;
      S_F_UN:   state_nxt = S_F_RD;
      S_F_PUSH: state_nxt = S_F_PB;
      S_F_PB:   state_nxt = S_DONE;
      S_DONE:   if (st.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = CMD_NONE;
    in_ready = 1'b0;
    unique case (state_r)
      S_INIT:   cmd = CMD_SWEEP;
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd = CMD_LOAD;
      end
      S_DISP: begin
        case (st.op)
          OP_ALLOC: if (st.req_bad) cmd = CMD_ST_BADORD;
          OP_FREE:  cmd = st.pg_oob ? CMD_ST_BADFREE : CMD_ABITS_RD;
          default:  cmd = CMD_NONE;
        endcase
      end
      S_RB_CLR: cmd = CMD_SWEEP;
      S_RB_FIT: begin
        if (st.fit) cmd = CMD_PUSH_RB;
        else if (!st.ord_zero) cmd = CMD_ORD_DEC;
      end
      S_RB_PB:  cmd = CMD_PUSH_B;
      S_A_CHK: begin
        if (!st.head_empty) cmd = CMD_POP_RD;
        else if (st.ord_last) cmd = CMD_ST_NOSPACE;
        else cmd = CMD_ORD_INC;
      end
      S_A_POP:  cmd = CMD_POP_WR;
      S_A_MARK: cmd = CMD_MARK;
      S_A_SPL:  if (st.split_more) cmd = CMD_ORD_DEC;
      S_A_PUSH: cmd = CMD_PUSH_SPLIT;
      S_A_PB:   cmd = CMD_PUSH_B;
      S_F_SRCH: cmd = st.found ? CMD_F_FOUND : CMD_ST_BADFREE;
      S_F_RD:   cmd = CMD_ABITS_RD;
      S_F_CLR:  cmd = CMD_F_CLR;
      S_F_BUD: begin
        if (!st.bud_alloc) cmd = st.bud_is_head ? CMD_UH_RD : CMD_UN_RD;
      end
      S_F_UH:   cmd = CMD_UH_WR;
      S_F_UN:   cmd = CMD_UN_WR;
      S_F_PUSH: cmd = CMD_PUSH_FREE;
      S_F_PB:   cmd = CMD_PUSH_B;
      S_DONE:   if (st.out_free) cmd = CMD_EMIT;
      default:  cmd = CMD_NONE;
    endcase
  end

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DISP))
    else $error("accepted request not dispatched");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_EMIT) |-> st.out_free)
    else $error("result emitted over a pending one");

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && st.out_free) |=> (state_r == S_IDLE && in_ready))
    else $error("block did not return to idle after result");

endmodule
`default_nettype wire

@@ rtl/bpa_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_dp
// Allocator datapath: allocated bitmap and link memories, list heads,
// working registers and the result register.
// ----------------------------------------------------------------------------
module bpa_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bpa_pkg::cmd_t                cmd,
  output bpa_pkg::dp_status_t          st,
  input  logic [bpa_pkg::OP_W-1:0]     ld_opcode,
  input  logic [bpa_pkg::ORD_W-1:0]    ld_req_order,
  input  logic [bpa_pkg::PAGE_W-1:0]   ld_rel_page,
  input  logic                         cfg_we,
  input  logic [bpa_pkg::CFG_W-1:0]    cfg_data,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic [bpa_pkg::STAT_W-1:0]   res_status,
  output logic [bpa_pkg::PAGE_W-1:0]   res_page,
  output logic [bpa_pkg::ORD_W-1:0]    res_order
);
  import bpa_pkg::*;

  logic [OP_W-1:0]       op_r;
  logic [ORD_W-1:0]      req_r, ord_r;
  logic [LINK_W-1:0]     pg_r, blk_r, tmp_r, pp_r;
  logic [LINK_W-1:0]     head_r [NUM_ORDERS];
  logic [CFG_W-1:0]      page_count_r;
  logic [STAT_W-1:0]     acc_status_r;
  logic [PAGE_W-1:0]     acc_page_r;
  logic [ORD_W-1:0]      acc_order_r;
  logic                  out_valid_r;
  logic [STAT_W-1:0]     out_status_r;
  logic [PAGE_W-1:0]     out_page_r;
  logic [ORD_W-1:0]      out_order_r;

  logic [NUM_ORDERS-1:0] abits_mem [MAX_PAGES];
  logic [LINK_W-1:0]     nxt_mem [MAX_PAGES];
  logic [LINK_W-1:0]     prv_mem [MAX_PAGES];
  logic [NUM_ORDERS-1:0] abits_rd_r;
  logic [LINK_W-1:0]     nxt_rd_r, prv_rd_r;

  logic                  ab_we, nx_we, pv_we;
  logic [PAGE_W-1:0]     ab_wa, ab_ra, nx_wa, nx_ra, pv_wa, pv_ra;
  logic [NUM_ORDERS-1:0] ab_wd;
  logic [LINK_W-1:0]     nx_wd, pv_wd;

  logic [OIX_W-1:0]      oix;
  logic [LINK_W-1:0]     n_pages, head_cur, sz, bud, min_pg, push_pg;
  logic                  push_ok;
  logic [NUM_ORDERS-1:0] mark_mask, ord_bit;
  logic                  found, stop;
  logic [ORD_W-1:0]      found_ord;

  assign oix      = ord_r[OIX_W-1:0];
  assign head_cur = head_r[oix];
  assign n_pages  = (page_count_r > NIL_PAGE) ? NIL_PAGE : page_count_r;
  assign sz       = LINK_W'(1) << ord_r;
  assign bud      = pg_r ^ sz;
  assign min_pg   = (bud < pg_r) ? bud : pg_r;
  assign push_pg  = (cmd == CMD_PUSH_SPLIT) ? (blk_r + sz) : pg_r;
  assign push_ok  = push_pg < NIL_PAGE;
  assign ord_bit  = NUM_ORDERS'(1) << oix;

  always_comb begin
    for (int o = 0; o < NUM_ORDERS; o++) begin
      mark_mask[o] = (ORD_W'(o) >= req_r) && (ORD_W'(o) <= ord_r);
    end
  end

  // lowest set order for which the page is still aligned
  always_comb begin
    found     = 1'b0;
    stop      = 1'b0;
    found_ord = '0;
    for (int o = 0; o < NUM_ORDERS; o++) begin
      if (!stop) begin
        if ((pg_r & ((LINK_W'(1) << o) - LINK_W'(1))) != '0) begin
          stop = 1'b1;
        end else if (abits_rd_r[o]) begin
          found     = 1'b1;
          found_ord = ORD_W'(o);
          stop      = 1'b1;
        end
      end
    end
  end

  always_comb begin
    st.op          = op_r;
    st.req_bad     = req_r >= ORD_W'(NUM_ORDERS);
    st.pg_oob      = pg_r >= n_pages;
    st.head_empty  = head_cur >= NIL_PAGE;
    st.ord_last    = ord_r == ORD_W'(NUM_ORDERS - 1);
    st.ord_zero    = ord_r == '0;
    st.fit         = ({1'b0, pg_r} + {1'b0, sz}) <= {1'b0, n_pages};
    st.split_more  = ord_r > req_r;
    st.found       = found;
    st.bud_oob     = ({1'b0, bud} + {1'b0, sz}) > {1'b0, n_pages};
    st.bud_alloc   = abits_rd_r[oix];
    st.bud_is_head = bud == head_cur;
    st.sweep_last  = pg_r == LINK_W'(MAX_PAGES - 1);
    st.out_free    = !out_valid_r || res_ready;
  end

  // memory port steering
  always_comb begin
    ab_we = 1'b0; ab_wa = '0; ab_wd = '0; ab_ra = '0;
    nx_we = 1'b0; nx_wa = '0; nx_wd = '0; nx_ra = '0;
    pv_we = 1'b0; pv_wa = '0; pv_wd = '0; pv_ra = '0;
    case (cmd)
      CMD_SWEEP: begin
        ab_we = 1'b1;
        ab_wa = pg_r[PAGE_W-1:0];
      end
      CMD_ABITS_RD: ab_ra = pg_r[PAGE_W-1:0];
      CMD_PUSH_RB, CMD_PUSH_SPLIT, CMD_PUSH_FREE: begin
        if (push_ok) begin
          nx_we = 1'b1;
          nx_wa = push_pg[PAGE_W-1:0];
          nx_wd = head_cur;
          pv_we = 1'b1;
          pv_wa = push_pg[PAGE_W-1:0];
          pv_wd = NIL_PAGE;
        end
      end
      CMD_PUSH_B: begin
        if (tmp_r < NIL_PAGE) begin
          pv_we = 1'b1;
          pv_wa = tmp_r[PAGE_W-1:0];
          pv_wd = pp_r;
        end
      end
      CMD_POP_RD: nx_ra = head_cur[PAGE_W-1:0];
      CMD_POP_WR, CMD_UH_WR: begin
        if (nxt_rd_r < NIL_PAGE) begin
          pv_we = 1'b1;
          pv_wa = nxt_rd_r[PAGE_W-1:0];
          pv_wd = NIL_PAGE;
        end
        ab_ra = blk_r[PAGE_W-1:0];
      end
      CMD_MARK: begin
        ab_we = 1'b1;
        ab_wa = blk_r[PAGE_W-1:0];
        ab_wd = abits_rd_r | mark_mask;
      end
      CMD_F_CLR: begin
        ab_we = 1'b1;
        ab_wa = pg_r[PAGE_W-1:0];
        ab_wd = abits_rd_r & ~ord_bit;
        ab_ra = bud[PAGE_W-1:0];
      end
      CMD_UH_RD: nx_ra = bud[PAGE_W-1:0];
      CMD_UN_RD: begin
        nx_ra = bud[PAGE_W-1:0];
        pv_ra = bud[PAGE_W-1:0];
      end
      CMD_UN_WR: begin
        if (prv_rd_r < NIL_PAGE) begin
          nx_we = 1'b1;
          nx_wa = prv_rd_r[PAGE_W-1:0];
          nx_wd = nxt_rd_r;
        end
        if (nxt_rd_r < NIL_PAGE) begin
          pv_we = 1'b1;
          pv_wa = nxt_rd_r[PAGE_W-1:0];
          pv_wd = prv_rd_r;
        end
      end
      default: ab_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ab_we) abits_mem[ab_wa] <= ab_wd;
    abits_rd_r <= abits_mem[ab_ra];
  end

  always_ff @(posedge clk) begin
    if (nx_we) nxt_mem[nx_wa] <= nx_wd;
    nxt_rd_r <= nxt_mem[nx_ra];
  end

  always_ff @(posedge clk) begin
    if (pv_we) prv_mem[pv_wa] <= pv_wd;
    prv_rd_r <= prv_mem[pv_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pg_r         <= '0;
      ord_r        <= '0;
      page_count_r <= CFG_W'(MAX_PAGES);
      out_valid_r  <= 1'b0;
      for (int o = 0; o < NUM_ORDERS; o++) head_r[o] <= NIL_PAGE;
    end else begin
      if (cfg_we) page_count_r <= cfg_data;
      if (out_valid_r && res_ready && cmd != CMD_EMIT) out_valid_r <= 1'b0;
      case (cmd)
        CMD_LOAD: begin
          op_r         <= ld_opcode;
          req_r        <= ld_req_order;
          pg_r         <= (ld_opcode == OP_REBUILD) ? '0 : {1'b0, ld_rel_page};
          ord_r        <= (ld_opcode == OP_ALLOC) ? ld_req_order : '0;
          acc_status_r <= ST_OK;
          acc_page_r   <= '0;
          acc_order_r  <= '0;
          if (ld_opcode == OP_REBUILD) begin
            for (int o = 0; o < NUM_ORDERS; o++) head_r[o] <= NIL_PAGE;
          end
        end
        CMD_SWEEP: begin
          pg_r  <= st.sweep_last ? '0 : pg_r + LINK_W'(1);
          ord_r <= ORD_W'(NUM_ORDERS - 1);
        end
        CMD_ST_BADORD:  acc_status_r <= ST_BAD_ORDER;
        CMD_ST_NOSPACE: acc_status_r <= ST_NO_SPACE;
        CMD_ST_BADFREE: acc_status_r <= ST_BAD_FREE;
        CMD_ORD_INC:    ord_r <= ord_r + ORD_W'(1);
        CMD_ORD_DEC:    ord_r <= ord_r - ORD_W'(1);
        CMD_PUSH_RB, CMD_PUSH_SPLIT, CMD_PUSH_FREE: begin
          if (push_ok) head_r[oix] <= push_pg;
          tmp_r <= push_ok ? head_cur : NIL_PAGE;
          pp_r  <= push_pg;
          if (cmd == CMD_PUSH_RB) pg_r <= pg_r + sz;
          if (cmd == CMD_PUSH_FREE) acc_order_r <= ord_r;
        end
        CMD_POP_RD: blk_r <= head_cur;
        CMD_POP_WR: head_r[oix] <= nxt_rd_r;
        CMD_MARK: begin
          acc_page_r  <= blk_r[PAGE_W-1:0];
          acc_order_r <= req_r;
        end
        CMD_F_FOUND: ord_r <= found_ord;
        CMD_UH_WR: begin
          head_r[oix] <= nxt_rd_r;
          ord_r       <= ord_r + ORD_W'(1);
          pg_r        <= min_pg;
        end
        CMD_UN_WR: begin
          ord_r <= ord_r + ORD_W'(1);
          pg_r  <= min_pg;
        end
        CMD_EMIT: begin
          out_valid_r  <= 1'b1;
          out_status_r <= acc_status_r;
          out_page_r   <= acc_page_r;
          out_order_r  <= acc_order_r;
        end
        default: ord_r <= ord_r;
      endcase
    end
  end

  assign res_valid  = out_valid_r;
  assign res_status = out_status_r;
  assign res_page   = out_page_r;
  assign res_order  = out_order_r;

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the buddy page allocator: a shadow allocator
// predicts status, granted page and order for every accepted request, and
// each result is compared in order while both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import bpa_pkg::*;

  localparam int    NIL_IX    = MAX_PAGES;
  localparam longint CYC_LIMIT = 2000000;

  typedef struct {
    status_t st;
    int      page;
    int      ord;
  } alloc_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_data;

  bpa_in_if  in_if();
  bpa_out_if out_if();

  buddy_page_allocator_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // shadow allocator state
  int unsigned shadow_count;
  bit          shadow_bits[NUM_ORDERS][MAX_PAGES];
  int          shadow_head[NUM_ORDERS];
  int          shadow_next[MAX_PAGES];
  int          shadow_prev[MAX_PAGES];

  alloc_result_t pending_results[$];
  int            live_pages[$];
  int            fail_cnt;
  longint        cyc_cnt;
  bit            calm;
  bit            hold_req;
  int            stall_left;
  int            hold_left;

  always #2 clk = ~clk;

  function automatic int usable_pages();
    return (shadow_count > MAX_PAGES) ? MAX_PAGES : int'(shadow_count);
  endfunction

  function automatic void push_block(int o, int p);
    int old;
    old = shadow_head[o];
    shadow_prev[p] = NIL_IX;
    shadow_next[p] = old;
    if (old < NIL_IX) shadow_prev[old] = p;
    shadow_head[o] = p;
  endfunction

  function automatic int pop_block(int o);
    int top;
    int nx;
    top = shadow_head[o];
    if (top >= NIL_IX) return NIL_IX;
    nx = shadow_next[top];
    if (nx < NIL_IX) shadow_prev[nx] = NIL_IX;
    shadow_head[o] = nx;
    return top;
  endfunction

  function automatic void unlink_block(int o, int p);
    int pv;
    int nx;
    nx = shadow_next[p];
    if (p == shadow_head[o]) begin
      shadow_head[o] = nx;
      if (nx < NIL_IX) shadow_prev[nx] = NIL_IX;
      return;
    end
    pv = shadow_prev[p];
    if (pv < NIL_IX) shadow_next[pv] = nx;
    if (nx < NIL_IX) shadow_prev[nx] = pv;
  endfunction

  function automatic void rebuild_lists();
    int n;
    int p;
    int sz;
    n = usable_pages();
    p = 0;
    foreach (shadow_bits[o, i]) shadow_bits[o][i] = 0;
    for (int o = 0; o < NUM_ORDERS; o++) shadow_head[o] = NIL_IX;
    for (int o = NUM_ORDERS - 1; o >= 0; o--) begin
      sz = 1 << o;
      while (p + sz <= n) begin
        push_block(o, p);
        p += sz;
      end
    end
  endfunction

  function automatic alloc_result_t predict_request(logic [OP_W-1:0] op,
                                                    logic [ORD_W-1:0] rord,
                                                    logic [PAGE_W-1:0] pidx);
    alloc_result_t r;
    int o;
    int blk;
    int child;
    int n;
    int p;
    int sz;
    int bud;
    bit found;
    r.st = ST_OK;
    r.page = 0;
    r.ord = 0;
    case (op)
      OP_REBUILD: rebuild_lists();
      OP_ALLOC: begin
        if (rord >= NUM_ORDERS) begin
          r.st = ST_BAD_ORDER;
        end else begin
          blk = NIL_IX;
          for (o = rord; o < NUM_ORDERS; o++) begin
            blk = pop_block(o);
            if (blk < NIL_IX) break;
          end
          if (blk >= NIL_IX) begin
            r.st = ST_NO_SPACE;
          end else begin
            shadow_bits[o][blk] = 1;
            while (o > rord) begin
              child = o - 1;
              shadow_bits[child][blk] = 1;
              if (blk + (1 << child) < NIL_IX) push_block(child, blk + (1 << child));
              o = child;
            end
            r.page = blk & 12'hfff;
            r.ord = rord;
          end
        end
      end
      OP_FREE: begin
        n = usable_pages();
        p = pidx;
        o = 0;
        found = 0;
        if (p < n) begin
          for (o = 0; o < NUM_ORDERS; o++) begin
            if ((p & ((1 << o) - 1)) != 0) break;
            if (shadow_bits[o][p]) begin
              found = 1;
              break;
            end
          end
        end
        if (!found) begin
          r.st = ST_BAD_FREE;
        end else begin
          while (1) begin
            shadow_bits[o][p] = 0;
            if (o == NUM_ORDERS - 1) break;
            sz = 1 << o;
            bud = p ^ sz;
            if (bud + sz > n) break;
            if (shadow_bits[o][bud]) break;
            unlink_block(o, bud);
            o++;
            if (bud < p) p = bud;
          end
          push_block(o, p);
          r.ord = o & 15;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one request and wait for it to be taken
  task automatic send_request(logic [OP_W-1:0] op, logic [ORD_W-1:0] rord,
                              logic [PAGE_W-1:0] pidx);
    alloc_result_t r;
    int gap;
    in_if.valid     <= 1'b1;
    in_if.opcode    <= op;
    in_if.req_order <= rord;
    in_if.rel_page  <= pidx;
    do @(posedge clk); while (!in_if.ready);
    r = predict_request(op, rord, pidx);
    pending_results.push_back(r);
    if (r.st == ST_OK) begin
      if (op == OP_ALLOC) live_pages.push_back(r.page);
      if (op == OP_FREE) begin
        foreach (live_pages[i]) begin
          if (live_pages[i] == pidx) begin
            live_pages.delete(i);
            break;
          end
        end
      end
      if (op == OP_REBUILD) live_pages.delete();
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // write page_count once all results are back, then rebuild
  task automatic set_page_count(int unsigned value);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= CFG_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_count = value & 13'h1fff;
    send_request(OP_REBUILD, ORD_W'($urandom), PAGE_W'($urandom));
  endtask

  task automatic test_startup();
    send_request(OP_ALLOC, 4'd0, 12'd0);
    send_request(OP_FREE, 4'd0, 12'd0);
    send_request(OP_NOP, 4'd15, 12'hfff);
  endtask

  task automatic test_full_range();
    set_page_count(4096);
    for (int o = 0; o < NUM_ORDERS; o++) send_request(OP_ALLOC, ORD_W'(o), 12'd0);
    send_request(OP_ALLOC, 4'd8, 12'd0);
    send_request(OP_ALLOC, 4'd15, 12'hfff);
    send_request(OP_FREE, 4'd0, 12'd3);
    send_request(OP_FREE, 4'd0, 12'hfff);
    while (live_pages.size() > 0) send_request(OP_FREE, 4'd0, PAGE_W'(live_pages[$]));
    // double free
    send_request(OP_FREE, 4'd0, 12'd0);
  endtask

  task automatic test_merge_limit();
    set_page_count(37);
    send_request(OP_ALLOC, 4'd0, 12'd0);
    send_request(OP_ALLOC, 4'd2, 12'd0);
    send_request(OP_ALLOC, 4'd0, 12'd0);
    send_request(OP_FREE, 4'd0, 12'd40);
    while (live_pages.size() > 0) send_request(OP_FREE, 4'd0, PAGE_W'(live_pages[0]));
    set_page_count(0);
    send_request(OP_ALLOC, 4'd0, 12'd0);
    send_request(OP_FREE, 4'd0, 12'd0);
    set_page_count(8191);
    send_request(OP_ALLOC, 4'd7, 12'd0);
    set_page_count(1);
    send_request(OP_ALLOC, 4'd0, 12'd0);
    send_request(OP_ALLOC, 4'd0, 12'd0);
  endtask

  task automatic random_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      send_request(OP_ALLOC, ORD_W'(($urandom_range(0, 19) == 0) ? $urandom_range(8, 15)
                   : $urandom_range(0, 7)), PAGE_W'($urandom));
    end else if (r < 85 && live_pages.size() > 0) begin
      send_request(OP_FREE, ORD_W'($urandom),
                   PAGE_W'(live_pages[$urandom_range(0, live_pages.size() - 1)]));
    end else if (r < 96) begin
      send_request(OP_FREE, ORD_W'($urandom), PAGE_W'($urandom));
    end else if (r < 99) begin
      send_request(OP_NOP, ORD_W'($urandom), PAGE_W'($urandom));
    end else begin
      send_request(OP_REBUILD, ORD_W'($urandom), PAGE_W'($urandom));
    end
  endtask

  task automatic test_random();
    int unsigned counts[6] = '{4096, 8191, 100, 0, 0, 0};
    counts[3] = $urandom_range(16, 4096);
    counts[4] = $urandom_range(1, 300);
    counts[5] = $urandom_range(0, 8191);
    foreach (counts[k]) begin
      set_page_count(counts[k]);
      for (int i = 0; i < 75; i++) begin
        calm = (i >= 30 && i < 45);
        random_request();
      end
      calm = 0;
    end
  endtask

  task automatic test_backpressure();
    set_page_count(256);
    hold_req = 1;
    for (int i = 0; i < 20; i++) random_request();
  endtask

  // result side ready with random stalls and one long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_req) begin
      out_if.ready <= 1'b0;
      if (hold_left == 0) hold_left = 400;
      else if (hold_left == 1) begin
        hold_left = 0;
        hold_req = 0;
      end else hold_left--;
    end else if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else begin
      out_if.ready <= 1'b1;
      if (!calm) begin
        case ($urandom_range(0, 99)) inside
          [0:11]:  stall_left = $urandom_range(1, 3);
          [12:14]: stall_left = $urandom_range(20, 60);
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    alloc_result_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d page=%0d order=%0d", $time,
                 out_if.status, out_if.block_page, out_if.final_order);
        fail_cnt++;
      end else begin
        e = pending_results.pop_front();
        if (out_if.status !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, out_if.status);
          fail_cnt++;
        end
        if (out_if.block_page !== PAGE_W'(e.page)) begin
          $display("%0t: block_page expected %0d actual %0d", $time, e.page,
                   out_if.block_page);
          fail_cnt++;
        end
        if (out_if.final_order !== ORD_W'(e.ord)) begin
          $display("%0t: final_order expected %0d actual %0d", $time, e.ord,
                   out_if.final_order);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc_cnt++;
    if (cyc_cnt > CYC_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    clk = 0;
    rst_n = 0;
    cfg_we = 0;
    cfg_data = '0;
    in_if.valid = 0;
    in_if.opcode = '0;
    in_if.req_order = '0;
    in_if.rel_page = '0;
    out_if.ready = 0;
    fail_cnt = 0;
    cyc_cnt = 0;
    calm = 0;
    hold_req = 0;
    stall_left = 0;
    hold_left = 0;
    shadow_count = 4096;
    foreach (shadow_bits[o, i]) shadow_bits[o][i] = 0;
    foreach (shadow_head[o]) shadow_head[o] = NIL_IX;
    foreach (shadow_next[i]) begin
      shadow_next[i] = 0;
      shadow_prev[i] = 0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_startup();
    test_full_range();
    test_merge_limit();
    test_backpressure();
    test_random();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/bpa_pkg.sv
rtl/bpa_ifs.sv
rtl/bpa_ctrl.sv
rtl/bpa_dp.sv
rtl/buddy_page_allocator_top.sv
tb/tb_top.sv
